// ===== src/lpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpsc_pkg
// Shared types and constants for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
package lpsc_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned LEN_W        = 32;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd2;

   localparam logic [BYTE_W-1:0] SC_ZERO_BYTE = 8'h00;
   localparam logic [BYTE_W-1:0] SC_LAST_BYTE = 8'h01;
   localparam logic [1:0]        SC_LAST_IDX  = 2'd3;
   localparam logic [1:0]        HDR_LAST_IDX = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_PASS,
      PH_SWALLOW
   } phase_type;

   // what the back end has to emit for one queued entry
   typedef enum logic [1:0] {
      ACT_SINGLE,
      ACT_START,
      ACT_BYTE_TRUNC
   } act_kind_type;

   typedef struct packed {
      act_kind_type        kind;
      logic [BYTE_W-1:0]   data;
      logic                byte_valid;
      logic [STATUS_W-1:0] status;
      logic                end_flag;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/lpsc_req_if.sv =====
// ----------------------------------------------------------------------------
// lpsc_req_if
// Input byte channel: valid/ready handshake with one buffer byte per transaction.
// ----------------------------------------------------------------------------
interface lpsc_req_if
   import lpsc_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic [LEN_W-1:0]  buffer_length;
   logic              last_byte;

   modport source (output valid, data_byte, buffer_length, last_byte, input ready);
   modport sink   (input valid, data_byte, buffer_length, last_byte, output ready);
endinterface

// ===== src/lpsc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lpsc_rsp_if
// Result channel: valid/ready handshake with one converted result per transaction.
// ----------------------------------------------------------------------------
interface lpsc_rsp_if
   import lpsc_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                byte_valid;
   logic [STATUS_W-1:0] status;
   logic                end_of_buffer;

   modport source (output valid, out_byte, byte_valid, status, end_of_buffer, input ready);
   modport sink   (input valid, out_byte, byte_valid, status, end_of_buffer, output ready);
endinterface

// ===== src/lpsc_front.sv =====
// ----------------------------------------------------------------------------
// lpsc_front
// Parses the length-prefixed byte stream and posts one action per byte that
// yields output into the queue.
// ----------------------------------------------------------------------------
module lpsc_front
   import lpsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   lpsc_req_if.sink         req,
   input  queue_status_type q_status,
   output push_type         push
);

   phase_type          phase_ff, phase_in;
   logic [1:0]         header_count_ff, header_count_in;
   logic [LEN_W-9:0]   length_accum_ff, length_accum_in;
   logic [LEN_W-1:0]   payload_left_ff, payload_left_in;
   logic [LEN_W-1:0]   bytes_left_ff, bytes_left_in;
   logic               first_header_ff, first_header_in;

   logic               accept;
   logic [LEN_W-1:0]   bl_cur;
   logic               overrun;
   logic [LEN_W-1:0]   bl_next;
   logic [LEN_W-1:0]   unit_len;
   logic [LEN_W-1:0]   pl_dec;
   logic               last;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;
   assign last      = req.last_byte;

   // buffer length is latched on the first byte of each buffer
   assign bl_cur   = (phase_ff == PH_HEADER && first_header_ff && header_count_ff == 2'd0)
                     ? req.buffer_length : bytes_left_ff;
   assign overrun  = (bl_cur == '0);
   assign bl_next  = overrun ? bl_cur : bl_cur - LEN_W'(1);
   assign unit_len = {length_accum_ff, req.data_byte};
   assign pl_dec   = payload_left_ff - LEN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= 2'd0;
         length_accum_ff <= '0;
         payload_left_ff <= '0;
         bytes_left_ff   <= '0;
         first_header_ff <= 1'b1;
      end else if (accept) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         length_accum_ff <= length_accum_in;
         payload_left_ff <= payload_left_in;
         bytes_left_ff   <= bytes_left_in;
         first_header_ff <= first_header_in;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      length_accum_in = length_accum_ff;
      payload_left_in = payload_left_ff;
      bytes_left_in   = bl_next;
      first_header_in = first_header_ff;
      push.valid      = 1'b0;
      push.entry      = '{kind: ACT_SINGLE, data: SC_ZERO_BYTE, byte_valid: 1'b0,
                          status: ST_OK, end_flag: 1'b0};

      case (phase_ff)
         PH_PASS: begin
            push.valid            = accept;
            push.entry.data       = req.data_byte;
            push.entry.byte_valid = 1'b1;
            push.entry.end_flag   = last;
         end
         PH_SWALLOW: begin
            push.valid          = accept && last;
            push.entry.end_flag = 1'b1;
         end
         PH_PAYLOAD: begin
            push.valid = accept;
            if (overrun) begin
               push.entry.status   = ST_TRUNC;
               push.entry.end_flag = last;
               phase_in            = PH_SWALLOW;
            end else begin
               push.entry.data       = req.data_byte;
               push.entry.byte_valid = 1'b1;
               payload_left_in       = pl_dec;
               if (pl_dec == '0) begin
                  phase_in            = PH_HEADER;
                  header_count_in     = 2'd0;
                  length_accum_in     = '0;
                  push.entry.end_flag = last;
               end else if (last) begin
                  push.entry.kind = ACT_BYTE_TRUNC;
               end
            end
         end
         PH_HEADER: begin
            if (overrun) begin
               push.valid          = accept;
               push.entry.status   = ST_TRUNC;
               push.entry.end_flag = last;
               phase_in            = PH_SWALLOW;
            end else if (header_count_ff != HDR_LAST_IDX) begin
               length_accum_in     = unit_len[LEN_W-9:0];
               header_count_in     = header_count_ff + 2'd1;
               push.valid          = accept && last;
               push.entry.status   = ST_TRUNC;
               push.entry.end_flag = 1'b1;
            end else begin
               header_count_in     = 2'd0;
               length_accum_in     = '0;
               first_header_in     = 1'b0;
               push.valid          = accept;
               push.entry.end_flag = last;
               // buffer already in start-code form
               if (first_header_ff && unit_len == LEN_W'(1) && req.buffer_length > LEN_W'(4)) begin
                  push.entry.kind = ACT_START;
                  phase_in        = PH_PASS;
               end else if (unit_len > req.buffer_length) begin
                  push.entry.status = ST_TOO_LONG;
                  phase_in          = PH_SWALLOW;
               end else if (unit_len > bl_next || (last && unit_len != '0)) begin
                  push.entry.status = ST_TRUNC;
                  phase_in          = PH_SWALLOW;
               end else begin
                  push.entry.kind = ACT_START;
                  if (unit_len != '0) begin
                     phase_in        = PH_PAYLOAD;
                     payload_left_in = unit_len;
                  end
               end
            end
         end
         default: begin
            phase_in = PH_HEADER;
         end
      endcase

      // every buffer starts from a clean slate
      if (last) begin
         phase_in        = PH_HEADER;
         header_count_in = 2'd0;
         length_accum_in = '0;
         payload_left_in = '0;
         bytes_left_in   = '0;
         first_header_in = 1'b1;
      end
   end

endmodule

// ===== src/lpsc_queue.sv =====
// ----------------------------------------------------------------------------
// lpsc_queue
// Small first-in first-out queue of actions between the parser and the emitter.
// ----------------------------------------------------------------------------
module lpsc_queue
   import lpsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type q_status
);

   entry_type             slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign q_status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push.valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ===== src/lpsc_back.sv =====
// ----------------------------------------------------------------------------
// lpsc_back
// Expands queued actions into result transactions: a start code becomes four
// bytes, a cut payload byte becomes the byte and a truncation status.
// ----------------------------------------------------------------------------
module lpsc_back
   import lpsc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head,
   input  queue_status_type q_status,
   output logic             pop,
   lpsc_rsp_if.source       rsp
);

   entry_type   cur_ff, cur_in;
   logic [1:0]  idx_ff, idx_in;
   logic        cur_valid_ff, cur_valid_in;
   logic        last_piece;
   logic        advance;

   always_comb begin
      case (cur_ff.kind)
         ACT_SINGLE:     last_piece = 1'b1;
         ACT_START:      last_piece = (idx_ff == SC_LAST_IDX);
         ACT_BYTE_TRUNC: last_piece = (idx_ff == 2'd1);
         default:        last_piece = 1'b1;
      endcase
   end

   assign advance = !cur_valid_ff || (rsp.ready && last_piece);
   assign pop     = advance && !q_status.empty;

   always_comb begin
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      cur_valid_in = cur_valid_ff;
      if (advance) begin
         cur_in       = head;
         idx_in       = 2'd0;
         cur_valid_in = !q_status.empty;
      end else if (rsp.ready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp.valid = cur_valid_ff;

   always_comb begin
      rsp.out_byte      = cur_ff.data;
      rsp.byte_valid    = cur_ff.byte_valid;
      rsp.status        = cur_ff.status;
      rsp.end_of_buffer = cur_ff.end_flag;
      case (cur_ff.kind)
         ACT_SINGLE: begin
         end
         ACT_START: begin
            rsp.out_byte      = (idx_ff == SC_LAST_IDX) ? SC_LAST_BYTE : SC_ZERO_BYTE;
            rsp.byte_valid    = 1'b1;
            rsp.status        = ST_OK;
            rsp.end_of_buffer = cur_ff.end_flag && (idx_ff == SC_LAST_IDX);
         end
         ACT_BYTE_TRUNC: begin
            // payload byte first, then the truncation status
            if (idx_ff == 2'd0) begin
               rsp.byte_valid    = 1'b1;
               rsp.status        = ST_OK;
               rsp.end_of_buffer = 1'b0;
            end else begin
               rsp.out_byte      = SC_ZERO_BYTE;
               rsp.byte_valid    = 1'b0;
               rsp.status        = ST_TRUNC;
               rsp.end_of_buffer = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== src/length_prefix_to_start_code_core.sv =====
// ----------------------------------------------------------------------------
// length_prefix_to_start_code_core
// Converts length-prefixed video units to start-code form, one byte per clock.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per clock whenever its four-entry action
// queue has room, and puts out one result per clock when the result side is
// ready. Each 4-byte length header is held back and leaves as the start code
// 00 00 00 01, a burst of four results built from one queue entry, so a
// steady stream runs at one byte per clock in and out. A byte that is taken
// is written into a queue slot by the accepting edge and is then loaded into
// the output register, from which it drives the result port.
// Errors are reported as status-only results; the rest of a buffer after an
// error is dropped and its last byte yields a single end-of-buffer result.
// ----------------------------------------------------------------------------
module length_prefix_to_start_code_core
   import lpsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lpsc_req_if.sink   req,
   lpsc_rsp_if.source rsp
);

   push_type         push;
   queue_status_type q_status;
   entry_type        head;
   logic             pop;

   lpsc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .q_status (q_status),
      .push     (push)
   );

   lpsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   lpsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule
